// ----- design/ntpcal_pkg.sv -----
// Shared constants and the month table for the NTP seconds to calendar date core.
package ntpcal_pkg;

   // Field widths of one item on either side.
   localparam int unsigned SecondsW = 32;
   localparam int unsigned ZoneW    = 5;
   localparam int unsigned YearW    = 11;
   localparam int unsigned MonthW   = 4;
   localparam int unsigned DayW     = 5;
   localparam int unsigned HourW    = 5;
   localparam int unsigned MinuteW  = 6;
   localparam int unsigned SecondW  = 6;
   localparam int unsigned RspFieldsW = YearW + MonthW + DayW + HourW + MinuteW + SecondW;
   localparam int unsigned RspDataW   = ((RspFieldsW + 7) / 8) * 8;

   // Configuration port.
   localparam int unsigned CsrAddrW = 3;
   localparam int unsigned CsrDataW = 32;
   localparam logic        RegZoneOffset = 1'b0;   // register index taken from paddr[2]
   localparam logic [ZoneW-1:0] ZoneReset = 5'd2;

   // Calendar constants.
   localparam int unsigned SecPerMin  = 60;
   localparam int unsigned SecPerHour = 3600;
   localparam int unsigned SecPerDay  = 86400;
   localparam int unsigned BaseYear   = 1900;
   localparam int unsigned YearDays   = 365;
   localparam int unsigned QuadDays   = 1461;

   // Reciprocals for division by a constant.
   // t / 86400 = (t >> 7) / 675, floor reciprocal, may come out one low.
   localparam logic [24:0] RecipDay   = 25'd25451658;   // floor(2^34 / 675)
   localparam int unsigned RecipDayK  = 34;
   // d / 1461, ceiling reciprocal, exact for d below 2^16.
   localparam logic [16:0] RecipQuad  = 17'd91868;      // ceil(2^27 / 1461)
   localparam int unsigned RecipQuadK = 27;
   // tod / 3600 = (tod >> 4) / 225, exact for tod below 86400.
   localparam logic [12:0] RecipHour  = 13'd4661;       // ceil(2^20 / 225)
   localparam int unsigned RecipHourK = 20;
   // rem / 60 = (rem >> 2) / 15, exact for rem below 3600.
   localparam logic [10:0] RecipMin   = 11'd1093;       // ceil(2^14 / 15)
   localparam int unsigned RecipMinK  = 14;

   // Day of year on which a month starts, counted from 0.
   function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
      logic [8:0] s;
      case (m)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd59;
         4'd3:    s = 9'd90;
         4'd4:    s = 9'd120;
         4'd5:    s = 9'd151;
         4'd6:    s = 9'd181;
         4'd7:    s = 9'd212;
         4'd8:    s = 9'd243;
         4'd9:    s = 9'd273;
         4'd10:   s = 9'd304;
         4'd11:   s = 9'd334;
         default: s = 9'd0;
      endcase
      if (leap && m >= 4'd2) begin
         s = s + 9'd1;
      end
      return s;
   endfunction

endpackage

// ----- design/ntp_seconds_to_calendar_date_core.sv -----
// Pipelined conversion of NTP era 0 seconds to local calendar date and time.
//
//  Channel   Direction  Handshake          Payload
//  req_      in         tvalid / tready    tdata: ntp_seconds
//  rsp_      out        tvalid / tready    tdata: year, month, day, hour, minute, second
//  csr_      in         APB write / read   zone_offset_hours at byte address 0
//
// Seven register stages; one item is taken each cycle unless all stages are full and rsp_tready is low.
// rsp_tvalid rises once the item has passed through the stage registers into the last one.
// The stages are split at the constant-reciprocal multiplications, at most one in series per stage.
// Reset (synchronous, active high) empties the pipeline and sets the offset to +2 hours.
// When rsp_tready is low, full stages hold and the pipeline still fills its empty stages.
module ntp_seconds_to_calendar_date_core
   import ntpcal_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Input items
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SecondsW-1:0] req_tdata,     // [31:0] ntp_seconds
   // Result items
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,     // [10:0] year, [14:11] month, [19:15] day,
                                              // [24:20] hour, [30:25] minute, [36:31] second
   // Configuration
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   localparam int unsigned NStage = 7;

   // ---------------------------------------------------------------- configuration
   logic [ZoneW-1:0] zone_ff, zone_in;

   always_comb begin
      zone_in = zone_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == RegZoneOffset) begin
         zone_in = csr_pwdata[ZoneW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZoneReset;
      end else begin
         zone_ff <= zone_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == RegZoneOffset) ?
                       {{(CsrDataW-ZoneW){1'b0}}, zone_ff} : '0;

   // ---------------------------------------------------------------- stage control
   // A stage moves on when it is empty or the stage after it moves on.
   logic [NStage-1:0] vld_ff;
   logic [NStage-1:0] adv;

   always_comb begin
      adv[NStage-1] = !vld_ff[NStage-1] || rsp_tready;
      for (int i = NStage - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NStage; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   assign req_tready = adv[0];

   // ---------------------------------------------------------------- stage 1: offset and saturate
   logic signed [17:0] off_secs;
   logic signed [33:0] adj_sum;
   logic [31:0]        s1_t_in, s1_t_ff;

   always_comb begin
      off_secs = 18'($signed(zone_ff) * $signed(18'sd3600));
      adj_sum  = $signed({2'b00, req_tdata}) + 34'(off_secs);
      if (adj_sum[33]) begin
         s1_t_in = '0;
      end else if (adj_sum[32]) begin
         s1_t_in = '1;
      end else begin
         s1_t_in = adj_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) s1_t_ff <= s1_t_in;
   end

   // ---------------------------------------------------------------- stage 2: day estimate
   logic [49:0] day_prod;
   logic [15:0] s2_q_in, s2_q_ff;
   logic [31:0] s2_t_ff;

   always_comb begin
      day_prod = 50'(s1_t_ff[31:7]) * 50'(RecipDay);
      s2_q_in  = day_prod[RecipDayK +: 16];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_q_ff <= s2_q_in;
         s2_t_ff <= s1_t_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3: correct day, time of day
   logic [32:0] day_back;
   logic [32:0] s3_diff;
   logic [17:0] s3_rem;
   logic [15:0] s3_days_in, s3_days_ff;
   logic [16:0] s3_tod_in, s3_tod_ff;

   always_comb begin
      day_back = 33'(s2_q_ff) * 33'(SecPerDay);
      s3_diff  = {1'b0, s2_t_ff} - day_back;
      s3_rem   = s3_diff[17:0];
      if (s3_rem >= 18'(SecPerDay)) begin
         s3_days_in = s2_q_ff + 16'd1;
         s3_tod_in  = 17'(s3_rem - 18'(SecPerDay));
      end else begin
         s3_days_in = s2_q_ff;
         s3_tod_in  = s3_rem[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_days_ff <= s3_days_in;
         s3_tod_ff  <= s3_tod_in;
      end
   end

   // ---------------------------------------------------------------- stage 4: leap cycle and hour
   // From 1901 on, every fourth year is a leap year up to 2036, so whole
   // cycles of 1461 days follow the non-leap year 1900.
   logic        s4_early_in, s4_early_ff;
   logic [15:0] s4_dp_in, s4_dp_ff;
   logic [32:0] quad_prod;
   logic [5:0]  s4_cyc_in, s4_cyc_ff;
   logic [25:0] hour_prod;
   logic [4:0]  s4_hour_in, s4_hour_ff;
   logic [8:0]  s4_doy0_ff;
   logic [16:0] s4_tod_ff;

   always_comb begin
      s4_early_in = s3_days_ff < 16'(YearDays);
      s4_dp_in    = s4_early_in ? 16'd0 : s3_days_ff - 16'(YearDays);
      quad_prod   = 33'(s4_dp_in) * 33'(RecipQuad);
      s4_cyc_in   = quad_prod[RecipQuadK +: 6];
      hour_prod   = 26'(s3_tod_ff[16:4]) * 26'(RecipHour);
      s4_hour_in  = hour_prod[RecipHourK +: 5];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_early_ff <= s4_early_in;
         s4_dp_ff    <= s4_dp_in;
         s4_cyc_ff   <= s4_cyc_in;
         s4_hour_ff  <= s4_hour_in;
         s4_doy0_ff  <= s3_days_ff[8:0];
         s4_tod_ff   <= s3_tod_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5: remainders
   logic [15:0] quad_back;
   logic [10:0] s5_r_in, s5_r_ff;
   logic [16:0] hour_back;
   logic [11:0] s5_hrem_in, s5_hrem_ff;
   logic        s5_early_ff;
   logic [8:0]  s5_doy0_ff;
   logic [5:0]  s5_cyc_ff;
   logic [4:0]  s5_hour_ff;

   always_comb begin
      quad_back  = 16'(s4_cyc_ff) * 16'(QuadDays);
      s5_r_in    = 11'(s4_dp_ff - quad_back);
      hour_back  = 17'(s4_hour_ff) * 17'(SecPerHour);
      s5_hrem_in = 12'(s4_tod_ff - hour_back);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_r_ff     <= s5_r_in;
         s5_hrem_ff  <= s5_hrem_in;
         s5_early_ff <= s4_early_ff;
         s5_doy0_ff  <= s4_doy0_ff;
         s5_cyc_ff   <= s4_cyc_ff;
         s5_hour_ff  <= s4_hour_ff;
      end
   end

   // ---------------------------------------------------------------- stage 6: year and minute
   logic [1:0]  yi;
   logic [10:0] year_in, year_ff;
   logic [8:0]  doy_in, doy_ff;
   logic        leap_in, leap_ff;
   logic [20:0] min_prod;
   logic [5:0]  minute_in, minute_ff;
   logic [11:0] s6_hrem_ff;
   logic [4:0]  s6_hour_ff;

   always_comb begin
      yi = 2'(32'(s5_r_ff >= 11'(YearDays)) + 32'(s5_r_ff >= 11'(2 * YearDays))
           + 32'(s5_r_ff >= 11'(3 * YearDays)));
      if (s5_early_ff) begin
         year_in = 11'(BaseYear);
         doy_in  = s5_doy0_ff;
         leap_in = 1'b0;
      end else begin
         year_in = 11'(BaseYear + 1) + {3'b000, s5_cyc_ff, 2'b00} + 11'(yi);
         doy_in  = 9'(s5_r_ff - 11'(yi) * 11'(YearDays));
         leap_in = (yi == 2'd3);
      end
      min_prod  = 21'(s5_hrem_ff[11:2]) * 21'(RecipMin);
      minute_in = min_prod[RecipMinK +: 6];
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         year_ff    <= year_in;
         doy_ff     <= doy_in;
         leap_ff    <= leap_in;
         minute_ff  <= minute_in;
         s6_hrem_ff <= s5_hrem_ff;
         s6_hour_ff <= s5_hour_ff;
      end
   end

   // ---------------------------------------------------------------- stage 7: month, day, second
   logic [3:0]  month_idx;
   logic [8:0]  mstart;
   logic [4:0]  day_in;
   logic [5:0]  second_in;
   logic [11:0] min_back;
   logic [10:0] o_year_ff;
   logic [3:0]  o_month_ff;
   logic [4:0]  o_day_ff;
   logic [4:0]  o_hour_ff;
   logic [5:0]  o_minute_ff;
   logic [5:0]  o_second_ff;

   always_comb begin
      month_idx = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (doy_ff >= month_start(4'(k), leap_ff)) begin
            month_idx = 4'(k);
         end
      end
      mstart    = month_start(month_idx, leap_ff);
      day_in    = 5'(doy_ff - mstart + 9'd1);
      min_back  = 12'(minute_ff) * 12'(SecPerMin);
      second_in = 6'(s6_hrem_ff - min_back);
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         o_year_ff   <= year_ff;
         o_month_ff  <= month_idx + 4'd1;
         o_day_ff    <= day_in;
         o_hour_ff   <= s6_hour_ff;
         o_minute_ff <= minute_ff;
         o_second_ff <= second_in;
      end
   end

   assign rsp_tvalid = vld_ff[NStage-1];
   assign rsp_tdata  = {{(RspDataW-RspFieldsW){1'b0}}, o_second_ff, o_minute_ff, o_hour_ff,
                        o_day_ff, o_month_ff, o_year_ff};

   // ---------------------------------------------------------------- assertions
   // The day estimate is never more than one day low.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> s3_rem < 18'(2 * SecPerDay))
      else $error("day estimate out of correction range");

   // The remainder within a leap cycle stays below one cycle, and the remainder within an hour below one hour.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> s5_r_in < 11'(QuadDays) && s5_hrem_in < 12'(SecPerHour))
      else $error("cycle or hour remainder out of range");

   // Every delivered result has each date and time field within its basic range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> o_month_ff >= 4'd1 && o_month_ff <= 4'd12 && o_day_ff >= 5'd1
                     && o_hour_ff < 5'd24 && o_minute_ff < 6'd60 && o_second_ff < 6'd60)
      else $error("result field out of range");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the NTP seconds to calendar date core.
`timescale 1ns / 100ps

module tb
   import ntpcal_pkg::*;
();

   // Local date and time as packed on rsp_tdata, year in the lowest bits.
   typedef struct packed {
      logic [SecondW-1:0] second;
      logic [MinuteW-1:0] minute;
      logic [HourW-1:0]   hour;
      logic [DayW-1:0]    day;
      logic [MonthW-1:0]  month;
      logic [YearW-1:0]   year;
   } civil_time_type;

   // One expected date together with what produced it, for the error lines.
   typedef struct {
      logic [SecondsW-1:0] secs;
      logic [ZoneW-1:0]    zone;
      civil_time_type      civil;
   } civil_expect_type;

   // One row of the directed table; typed rows carry their date written out.
   typedef struct {
      logic [ZoneW-1:0]    zone;
      logic [SecondsW-1:0] secs;
      bit                  typed;
      civil_time_type      civil;
   } date_row_type;

   localparam logic [CsrAddrW-1:0] CsrAddrZone  = {RegZoneOffset, 2'b00};
   localparam logic [CsrAddrW-1:0] CsrAddrSpare = {~RegZoneOffset, 2'b00};
   localparam logic [SecondsW-1:0] MaxStamp     = 32'hFFFF_FFFF;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SecondsW-1:0] req_tdata = '0;      // [31:0] ntp_seconds
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;           // [10:0] year, [14:11] month, [19:15] day,
                                             // [24:20] hour, [30:25] minute, [36:31] second
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr = '0;
   logic [CsrDataW-1:0] csr_pwdata = '0;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   civil_expect_type civil_q[$];
   date_row_type     date_rows[$];
   logic [ZoneW-1:0] zone_now = ZoneReset;
   bit               req_gaps_on = 1'b1;
   bit               rsp_stalls_on = 1'b1;
   int unsigned      long_hold_cycles = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      items_sent = 0;
   int unsigned      results_checked = 0;
   int unsigned      zone_settings = 1;

   ntp_seconds_to_calendar_date_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock with a 12 ns period.
   initial begin
      forever #6 clock = ~clock;
   end

   // Gregorian calendar helpers.
   function automatic bit leap_year(input int unsigned y);
      if (y % 4 != 0) return 1'b0;
      if (y % 100 != 0) return 1'b1;
      return (y % 400) == 0;
   endfunction

   function automatic int unsigned year_days(input int unsigned y);
      return leap_year(y) ? 366 : 365;
   endfunction

   // Month counted from 0, so 1 is February.
   function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
      case (m)
         1: begin
            return leap_year(y) ? 29 : 28;
         end
         3, 5, 8, 10: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   function automatic longint year_start_seconds(input int unsigned y);
      longint s;
      s = 0;
      for (int unsigned k = BaseYear; k < y; k++) begin
         s += longint'(year_days(k)) * longint'(SecPerDay);
      end
      return s;
   endfunction

   // Local date for a timestamp under a zone offset, saturating at both ends of era 0.
   function automatic civil_time_type civil_from_ntp(input logic [SecondsW-1:0] secs,
                                                     input logic [ZoneW-1:0] zone);
      longint         adj;
      int unsigned    days;
      int unsigned    tod;
      int unsigned    yr;
      int unsigned    mon;
      civil_time_type c;
      adj = longint'(secs) + longint'($signed(zone)) * longint'(SecPerHour);
      if (adj < 0) adj = 0;
      if (adj > longint'(MaxStamp)) adj = longint'(MaxStamp);
      days = int'(adj / longint'(SecPerDay));
      tod  = int'(adj % longint'(SecPerDay));
      yr = BaseYear;
      while (days >= year_days(yr)) begin
         days -= year_days(yr);
         yr++;
      end
      mon = 0;
      while (mon < 11 && days >= month_days(mon, yr)) begin
         days -= month_days(mon, yr);
         mon++;
      end
      c.year   = yr[YearW-1:0];
      c.month  = 4'(mon + 1);
      c.day    = 5'(days + 1);
      c.hour   = 5'(tod / SecPerHour);
      c.minute = 6'((tod / SecPerMin) % 60);
      c.second = 6'(tod % SecPerMin);
      return c;
   endfunction

   function automatic civil_time_type civil_of(input int y, input int mo, input int d,
                                               input int h, input int mi, input int s);
      civil_time_type c;
      c.year   = y[YearW-1:0];
      c.month  = mo[MonthW-1:0];
      c.day    = d[DayW-1:0];
      c.hour   = h[HourW-1:0];
      c.minute = mi[MinuteW-1:0];
      c.second = s[SecondW-1:0];
      return c;
   endfunction

   // Random timestamps: uniform, near both ends, around new year and around leap days.
   function automatic logic [SecondsW-1:0] pick_seconds();
      longint      s;
      int unsigned y;
      y = $urandom_range(BaseYear, 2035);
      case ($urandom_range(0, 5))
         0, 1: begin
            s = longint'($urandom);
         end
         2: begin
            s = longint'($urandom_range(0, 200000));
         end
         3: begin
            s = longint'(MaxStamp) - longint'($urandom_range(0, 200000));
         end
         4: begin
            s = year_start_seconds(y) + longint'($urandom_range(0, 100000)) - 50000;
         end
         default: begin
            s = year_start_seconds(y)
                + longint'($urandom_range(58, 60)) * longint'(SecPerDay)
                + longint'($urandom_range(0, SecPerDay - 1));
         end
      endcase
      if (s < 0) s = 0;
      if (s > longint'(MaxStamp)) s = longint'(MaxStamp);
      return s[SecondsW-1:0];
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("ERROR at %0t: %s", $realtime, what);
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want, input civil_expect_type e);
      if (got !== want) begin
         flag_mismatch($sformatf("%s got %0d, expected %0d (seconds 0x%08h, zone %0d)",
                                 name, got, want, e.secs, $signed(e.zone)));
      end
   endtask

   task automatic add_row(input logic [ZoneW-1:0] zone, input logic [SecondsW-1:0] secs,
                          input bit typed, input civil_time_type civil);
      date_rows.push_back(date_row_type'{zone, secs, typed, civil});
   endtask

   // Offer one timestamp, after a random gap when gaps are on, and note its expected date once taken.
   task automatic offer_seconds(input logic [SecondsW-1:0] secs, input bit typed,
                                input civil_time_type typed_civil);
      int unsigned      gap;
      civil_expect_type e;
      gap = req_gaps_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= secs;
      do @(posedge clock); while (!req_tready);
      e.secs  = secs;
      e.zone  = zone_now;
      e.civil = typed ? typed_civil : civil_from_ntp(secs, zone_now);
      civil_q.push_back(e);
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (civil_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrAddrW-1:0] addr, input logic [CsrDataW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr[2] == RegZoneOffset) zone_now = data[ZoneW-1:0];
   endtask

   task automatic csr_check_zone();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CsrAddrZone;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[ZoneW-1:0] !== zone_now) begin
         flag_mismatch($sformatf("zone offset read back 0x%02h, expected 0x%02h",
                                 csr_prdata[ZoneW-1:0], zone_now));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // New offset only once the pipeline is empty; upper data bits are noise.
   task automatic retune_zone(input logic [ZoneW-1:0] zone);
      drain_results();
      csr_write(CsrAddrZone, {$urandom} & ~32'h1F | 32'(zone));
      csr_check_zone();
      zone_settings++;
   endtask

   // Result side: random stalls, with a long hold-off on request.
   initial begin : result_sink
      int unsigned stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_stalls_on ? $urandom_range(0, 15) : 0;
         if (long_hold_cycles != 0) begin
            stall = long_hold_cycles;
            long_hold_cycles = 0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Compare every result item with the oldest expected date.
   always @(posedge clock) begin : check_results
      civil_expect_type want;
      civil_time_type   got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (civil_q.size() == 0) begin
            flag_mismatch($sformatf("result 0x%010h with no date expected", rsp_tdata));
         end else begin
            want = civil_q.pop_front();
            got  = rsp_tdata[RspFieldsW-1:0];
            compare_field("year",   16'(got.year),   16'(want.civil.year),   want);
            compare_field("month",  16'(got.month),  16'(want.civil.month),  want);
            compare_field("day",    16'(got.day),    16'(want.civil.day),    want);
            compare_field("hour",   16'(got.hour),   16'(want.civil.hour),   want);
            compare_field("minute", 16'(got.minute), 16'(want.civil.minute), want);
            compare_field("second", 16'(got.second), 16'(want.civil.second), want);
            compare_field("padding", 16'(rsp_tdata[RspDataW-1:RspFieldsW]), 16'd0, want);
            results_checked++;
         end
      end
   end

   // Stimulus: directed table, a back-pressure burst, then random phases.
   initial begin : stimulus
      logic [ZoneW-1:0] z;
      civil_time_type   none;
      civil_time_type   top;
      none = '0;
      top  = civil_of(2036, 2, 7, 6, 28, 15);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset offset first, then each end of the offset range and the calendar edges.
      add_row(ZoneReset,  32'd0,          1'b1, civil_of(1900, 1, 1, 2, 0, 0));
      add_row(ZoneReset,  MaxStamp,       1'b1, top);
      add_row(5'd0,       32'd0,          1'b1, civil_of(1900, 1, 1, 0, 0, 0));
      add_row(5'd0,       MaxStamp,       1'b1, top);
      add_row(5'd0,       32'd86399,      1'b1, civil_of(1900, 1, 1, 23, 59, 59));
      add_row(5'd0,       32'd86400,      1'b1, civil_of(1900, 1, 2, 0, 0, 0));
      add_row(5'd0,       32'd5011200,    1'b1, civil_of(1900, 2, 28, 0, 0, 0));
      add_row(5'd0,       32'd5097600,    1'b1, civil_of(1900, 3, 1, 0, 0, 0));
      add_row(5'd0,       32'd131241600,  1'b1, civil_of(1904, 2, 29, 0, 0, 0));
      add_row(5'd0,       32'd3160771200, 1'b1, civil_of(2000, 2, 29, 0, 0, 0));
      add_row(5'd0,       32'd3187295999, 1'b1, civil_of(2000, 12, 31, 23, 59, 59));
      add_row(5'd0,       32'h5A5A_A5A5,  1'b0, none);
      add_row(5'(-12),    32'd0,          1'b1, civil_of(1900, 1, 1, 0, 0, 0));
      add_row(5'(-12),    32'd43200,      1'b1, civil_of(1900, 1, 1, 0, 0, 0));
      add_row(5'(-12),    32'd43201,      1'b0, none);
      add_row(5'(-12),    MaxStamp,       1'b0, none);
      add_row(5'd14,      32'd0,          1'b1, civil_of(1900, 1, 1, 14, 0, 0));
      add_row(5'd14,      MaxStamp,       1'b1, top);
      add_row(5'd14,      32'hA5A5_5A5A,  1'b0, none);
      // Offsets outside the documented range apply as they stand.
      add_row(5'(-16),    32'd57599,      1'b1, civil_of(1900, 1, 1, 0, 0, 0));
      add_row(5'(-16),    32'd57600,      1'b1, civil_of(1900, 1, 1, 0, 0, 0));
      add_row(5'd15,      32'd4294913295, 1'b1, top);
      add_row(5'd15,      32'd4294913294, 1'b0, none);
      add_row(5'(-1),     32'd31539599,   1'b1, civil_of(1900, 12, 31, 23, 59, 59));
      add_row(5'd1,       32'h7FFF_FFFF,  1'b0, none);

      foreach (date_rows[i]) begin
         if (date_rows[i].zone != zone_now) retune_zone(date_rows[i].zone);
         offer_seconds(date_rows[i].secs, date_rows[i].typed, date_rows[i].civil);
      end

      // A write to the spare address must leave the offset alone.
      drain_results();
      csr_write(CsrAddrSpare, {$urandom});
      csr_check_zone();

      // Hold the result side off while the input side streams, so the pipeline backs up.
      req_gaps_on = 1'b0;
      long_hold_cycles = 300;
      repeat (40) offer_seconds(pick_seconds(), 1'b0, none);

      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin
               z = 5'd0;
            end
            1: begin
               z = 5'(-12);
            end
            2: begin
               z = 5'd14;
            end
            3: begin
               z = 5'(-16);
            end
            4: begin
               z = 5'd15;
            end
            5: begin
               z = 5'(-13);
            end
            6: begin
               z = 5'd1;
            end
            default: begin
               z = 5'($urandom_range(0, 31));
            end
         endcase
         retune_zone(z);
         req_gaps_on   = $urandom_range(0, 2) != 0;
         rsp_stalls_on = $urandom_range(0, 2) != 0;
         repeat (53) offer_seconds(pick_seconds(), 1'b0, none);
      end

      drain_results();
      repeat (20) @(posedge clock);
      $display("Converted %0d timestamps under %0d offset settings, checked %0d dates,",
               items_sent, zone_settings, results_checked);
      $display("covering saturation at both ends, leap days and a long result stall.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Timed out waiting for the block");
      $display("Mismatches found");
      $finish;
   end

endmodule
